// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the DHT code builder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert on every clock edge outside reset
`define DHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assert an implication on every clock edge outside reset
`define DHT_ASSERT_IMPL(label, pre, post, msg) \
	`DHT_ASSERT(label, (pre) |-> (post), msg)

`endif

// ----- design/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// dht_pkg
// Types and constants of the JPEG DHT canonical code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

	localparam int MAX_CODE_BITS = 16;
	localparam logic [15:0] CODE_MASK = 16'((33'd1 << MAX_CODE_BITS) - 33'd1);
	localparam logic [3:0] LAST_POS = 4'd15;
	localparam int NUM_LENGTHS = 16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LENLO,
		PH_HEAD,
		PH_COUNT,
		PH_SYM
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       segment_start;
	} seg_word_t;

	typedef struct packed {
		logic [3:0]  table_class;
		logic [3:0]  table_number;
		logic [7:0]  symbol;
		logic [15:0] code_word;
		logic [4:0]  code_length;
		logic [15:0] length_mask;
		logic [11:0] symbol_index;
		logic        segment_end;
		logic        length_error;
	} res_word_t;

endpackage

`default_nettype wire

// ----- design/jpeg_dht_canonical_code_builder.sv -----
// The block reads a JPEG DHT segment one byte per cycle and gives one code word per
// symbol byte, or an error word when the segment length runs out inside a table.
// Every accepted byte is parsed in the cycle it is taken; its word, if any, is written to
// the result register, or to the skid register while the result side stalls. A two-entry
// output buffer (result register plus skid register) holds one extra word while the result
// side stalls. The input stalls only while the skid register is full, so bytes keep
// flowing at one per cycle until a second word waits behind a stalled one.
// ----------------------------------------------------------------------------
// jpeg_dht_canonical_code_builder
// Parses DHT length, header and count bytes and assigns canonical Huffman codes.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_dht_canonical_code_builder
	import dht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      seg_valid,
	output logic           seg_stall,
	input  wire seg_word_t seg_word,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_word_t      res_word
);

	phase_t      phase_q, phase_d;
	logic [15:0] left_q, left_d;
	logic [3:0]  pos_q, pos_d;
	logic [4:0]  len_q, len_d;
	logic [7:0]  sleft_q, sleft_d;
	logic [15:0] code_q, code_d;
	logic [11:0] emit_q, emit_d;
	logic [3:0]  cls_q, cls_d;
	logic [3:0]  num_q, num_d;

	logic [7:0]  counts_q [NUM_LENGTHS];
	logic [15:0] nz_q;

	logic        acc;
	logic [7:0]  b;
	logic        cnt_we;
	logic        r_v;
	logic        r_fail;
	logic [7:0]  r_sym;
	logic [15:0] r_code;
	logic [4:0]  r_len;
	logic [11:0] r_idx;
	logic        r_end;
	logic        r_err;
	res_word_t   r_w;
	logic [16:0] r_lm;

	logic [4:0]  start_bit;
	logic [15:0] nz_now;
	logic [16:0] low_mask;
	logic [15:0] cand;
	logic        found;
	logic [3:0]  pick;
	logic [4:0]  pick_len;
	logic [7:0]  pick_cnt;
	logic [15:0] left_dec;
	logic [15:0] full_len;
	logic [7:0]  sleft_dec;
	logic [15:0] code_inc;
	logic [3:0]  shamt;

	logic        res_valid_q;
	res_word_t   res_q;
	logic        skid_valid_q;
	res_word_t   skid_q;
	logic        out_free;

	assign acc = seg_valid && !seg_stall;
	assign b   = seg_word.data_byte;

	always_comb begin
		start_bit = (phase_q == PH_COUNT) ? 5'd0 : len_q;
		nz_now    = nz_q;
		if (phase_q == PH_COUNT) begin
			nz_now[LAST_POS] = (b != 8'd0);
		end
		low_mask = (17'd1 << start_bit) - 17'd1;
		cand     = nz_now & ~low_mask[15:0];
		found    = 1'b0;
		pick     = 4'd0;
		for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				pick  = 4'(i);
			end
		end
		pick_len = {1'b0, pick} + 5'd1;
		pick_cnt = (phase_q == PH_COUNT && pick == LAST_POS) ? b : counts_q[pick];
		shamt    = 4'(pick_len - len_q);
	end

	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		pos_d    = pos_q;
		len_d    = len_q;
		sleft_d  = sleft_q;
		code_d   = code_q;
		emit_d   = emit_q;
		cls_d    = cls_q;
		num_d    = num_q;
		cnt_we   = 1'b0;
		r_v      = 1'b0;
		r_fail   = 1'b0;
		r_sym    = 8'd0;
		r_code   = 16'd0;
		r_len    = 5'd0;
		r_idx    = 12'd0;
		r_end    = 1'b0;
		r_err    = 1'b0;
		left_dec = (left_q == 16'd0) ? 16'd0 : left_q - 16'd1;
		full_len = {left_q[15:8], b};
		sleft_dec = (sleft_q != 8'd0) ? sleft_q - 8'd1 : 8'd0;
		code_inc = (code_q + 16'd1) & CODE_MASK;

		if (seg_word.segment_start) begin
			left_d  = {b, 8'd0};
			phase_d = PH_LENLO;
		end else begin
			unique case (phase_q)
				PH_LENLO: begin
					if (full_len < 16'd2) begin
						r_fail = 1'b1;
					end else begin
						left_d  = full_len - 16'd2;
						phase_d = (full_len == 16'd2) ? PH_IDLE : PH_HEAD;
					end
				end
				PH_HEAD: begin
					cls_d = b[7:4];
					num_d = b[3:0];
					pos_d = 4'd0;
					if (left_q <= 16'd1) begin
						r_fail = 1'b1;
					end else begin
						left_d  = left_q - 16'd1;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					cnt_we = 1'b1;
					left_d = left_dec;
					if (pos_q != LAST_POS) begin
						pos_d = pos_q + 4'd1;
						if (left_dec == 16'd0) begin
							r_fail = 1'b1;
						end
					end else if (!found) begin
						phase_d = (left_dec == 16'd0) ? PH_IDLE : PH_HEAD;
					end else if (left_dec == 16'd0) begin
						r_fail = 1'b1;
					end else begin
						len_d   = pick_len;
						sleft_d = pick_cnt;
						code_d  = 16'd0;
						emit_d  = 12'd0;
						phase_d = PH_SYM;
					end
				end
				PH_SYM: begin
					r_v     = 1'b1;
					r_sym   = b;
					r_code  = code_q & CODE_MASK;
					r_len   = len_q;
					r_idx   = emit_q;
					emit_d  = emit_q + 12'd1;
					code_d  = code_inc;
					left_d  = left_dec;
					sleft_d = sleft_dec;
					if (sleft_dec == 8'd0 && found) begin
						code_d  = 16'(code_inc << shamt) & CODE_MASK;
						len_d   = pick_len;
						sleft_d = pick_cnt;
					end
					if (left_dec == 16'd0) begin
						phase_d = PH_IDLE;
						r_end   = 1'b1;
						r_err   = !(sleft_dec == 8'd0 && !found);
					end else if (sleft_dec == 8'd0 && !found) begin
						phase_d = PH_HEAD;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (r_fail) begin
				phase_d = PH_IDLE;
				left_d  = 16'd0;
				r_v     = 1'b1;
				r_end   = 1'b1;
				r_err   = 1'b1;
			end
		end

		r_lm = (17'd1 << r_len) - 17'd1;
		r_w.table_class  = cls_d;
		r_w.table_number = num_d;
		r_w.symbol       = r_sym;
		r_w.code_word    = r_code;
		r_w.code_length  = r_len;
		r_w.length_mask  = r_lm[15:0];
		r_w.symbol_index = r_idx;
		r_w.segment_end  = r_end;
		r_w.length_error = r_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= 16'd0;
			pos_q   <= 4'd0;
			len_q   <= 5'd1;
			sleft_q <= 8'd0;
			code_q  <= 16'd0;
			emit_q  <= 12'd0;
			cls_q   <= 4'd0;
			num_q   <= 4'd0;
		end else if (acc) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sleft_q <= sleft_d;
			code_q  <= code_d;
			emit_q  <= emit_d;
			cls_q   <= cls_d;
			num_q   <= num_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cnt_we) begin
			counts_q[pos_q] <= b;
			nz_q[pos_q]     <= (b != 8'd0);
		end
	end

	// result register plus skid stage
	assign out_free  = !res_valid_q || !res_stall;
	assign seg_stall = skid_valid_q;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= acc && r_v;
			end
		end else if (acc && r_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (acc && r_v) begin
				res_q <= r_w;
			end
		end else if (acc && r_v) begin
			skid_q <= r_w;
		end
	end

endmodule

`default_nettype wire

// ----- design/dht_checker.sv -----
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks of the DHT code builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dht_checker
	import dht_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      seg_valid,
	input wire logic      seg_stall,
	input wire seg_word_t seg_word,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire res_word_t res_word
);

	`DHT_ASSERT_IMPL(a_err_closes, res_valid && res_word.length_error, res_word.segment_end, "error word does not close segment")
	`DHT_ASSERT_IMPL(a_code_len, res_valid && !res_word.length_error, res_word.code_length != 5'd0 && res_word.code_length <= 5'd16, "code length out of range")
	`DHT_ASSERT_IMPL(a_mask_shape, res_valid, (res_word.length_mask & (res_word.length_mask + 16'd1)) == 16'd0, "length mask not contiguous low bits")
	`DHT_ASSERT_IMPL(a_stall_full, seg_stall, res_valid && $past(res_stall), "input stalled with result side free")
	`DHT_ASSERT(a_res_hold, $past(res_valid && res_stall) |-> res_valid && $stable(res_word), "stalled result word changed")

endmodule

bind jpeg_dht_canonical_code_builder dht_checker u_dht_checker (.*);

`default_nettype wire
